/* rtl/core/drm_pkg.sv */
// Shared constants, types and colour helpers for the diamond minimap rasterizer.
package drm_pkg;

  localparam int unsigned MaxMapTilesDef = 512;

  localparam int unsigned SizeW   = 10;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned ColourW = 3 * ChanW;

  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  localparam logic [SizeW-1:0] SizeResetVal = SizeW'(64);

  localparam logic RegIdxWidth  = 1'b0;
  localparam logic RegIdxHeight = 1'b1;

  typedef logic [ColourW-1:0] colour_t;
  typedef logic [ChanW-1:0]   chan_t;

  function automatic colour_t avg4(colour_t a, colour_t b, colour_t c, colour_t d);
    logic [ChanW+1:0] sum;
    colour_t          res;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      sum = {2'b00, a[i*ChanW +: ChanW]} + {2'b00, b[i*ChanW +: ChanW]}
          + {2'b00, c[i*ChanW +: ChanW]} + {2'b00, d[i*ChanW +: ChanW]};
      res[i*ChanW +: ChanW] = sum[ChanW+1:2];
    end
    return res;
  endfunction

endpackage

/* rtl/core/drm_column_store.sv */
// Column store: one colour per tile row, synchronous read-before-write memory.
module drm_column_store import drm_pkg::*; #(
  parameter int unsigned Depth = MaxMapTilesDef
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  colour_t                  wdata_i,
  output colour_t                  rdata_o
);

  colour_t mem_q [Depth];
  colour_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q        <= mem_q[addr_i];
      mem_q[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/diamond_minimap_rasterizer.sv */
// Top level: tile counters, column store access, blend stage and pixel output register.
// Order: an accepted tile is held in stage 1; its tile pixel, then any blended pixel, enters
//   the pixel output register. Throughput: one tile per cycle on the first row or column when
//   unstalled; a blended tile holds stage 1 until both pixels pass the single output channel.
// Reset: counters, neighbor colours and valids clear; sizes return to 64 x 64.
//   The column store is not cleared; its read data is used only after the entry was written.
module diamond_minimap_rasterizer import drm_pkg::*; #(
  parameter int unsigned MAX_MAP_TILES = MaxMapTilesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  chan_t             tile_red_i,
  input  chan_t             tile_green_i,
  input  chan_t             tile_blue_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] pixel_column_o,
  output logic [CoordW-1:0] pixel_row_o,
  output colour_t           pixel_colour_o,
  output logic              is_blended_o,
  output logic              last_of_run_o
);

  localparam int unsigned CntW = $clog2(MAX_MAP_TILES);
  localparam int unsigned SzW  = $clog2(MAX_MAP_TILES + 1);
  localparam int unsigned CmpW = (SzW > SizeW) ? SzW : SizeW;
  localparam int unsigned PosW = CmpW + 1;
  localparam logic [CmpW-1:0] MaxSize = CmpW'(MAX_MAP_TILES);

  logic [SizeW-1:0] width_q, height_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == RegIdxHeight) ? PdataW'(height_q) : PdataW'(width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeResetVal;
      height_q <= SizeResetVal;
    end else if (cfg_wr) begin
      if (paddr[2] == RegIdxHeight) begin
        height_q <= pwdata[SizeW-1:0];
      end else begin
        width_q <= pwdata[SizeW-1:0];
      end
    end
  end

  logic [CmpW-1:0] w_raw, h_raw, w_eff, h_eff;

  always_comb begin
    w_raw = CmpW'(width_q);
    h_raw = CmpW'(height_q);
    if (w_raw == '0) begin
      w_eff = CmpW'(1);
    end else if (w_raw > MaxSize) begin
      w_eff = MaxSize;
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = CmpW'(1);
    end else if (h_raw > MaxSize) begin
      h_eff = MaxSize;
    end else begin
      h_eff = h_raw;
    end
  end

  logic [CntW-1:0]   col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [CntW-1:0]   x_cur, y_cur;
  logic [CmpW-1:0]   x_inc, y_inc;
  logic [PosW-1:0]   col_sum, row_sum;
  logic              accept;
  colour_t           cur_colour;

  assign cur_colour = {tile_red_i, tile_green_i, tile_blue_i};

  always_comb begin
    x_cur   = (CmpW'(col_cnt_q) >= w_eff) ? '0 : col_cnt_q;
    y_cur   = (CmpW'(row_cnt_q) >= h_eff) ? '0 : row_cnt_q;
    x_inc   = CmpW'(x_cur) + CmpW'(1);
    y_inc   = CmpW'(y_cur) + CmpW'(1);
    col_sum = PosW'(x_cur) + PosW'(y_cur);
    row_sum = PosW'(x_cur) + PosW'(h_eff) - PosW'(y_cur) - PosW'(1);
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (accept) begin
      if (y_inc >= h_eff) begin
        row_cnt_d = '0;
        col_cnt_d = (x_inc >= w_eff) ? '0 : x_inc[CntW-1:0];
      end else begin
        row_cnt_d = y_inc[CntW-1:0];
        col_cnt_d = x_cur;
      end
    end
  end

  colour_t left_raw;

  drm_column_store #(
    .Depth (MAX_MAP_TILES)
  ) u_column_store (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_i  (y_cur),
    .wdata_i (cur_colour),
    .rdata_o (left_raw)
  );

  logic              s1_valid_q, s1_valid_d;
  logic              s1_phase_q, s1_phase_d;
  colour_t           s1_colour_q;
  logic [CoordW-1:0] s1_col_q, s1_row_q;
  logic              s1_xpos_q, s1_blend_q;
  colour_t           diag_q, diag_d, above_q, above_d;
  colour_t           left, avg;
  logic              out_free, emit, s1_done;

  logic              out_valid_q, out_valid_d;
  logic [CoordW-1:0] pix_col_q, pix_row_q;
  colour_t           pix_colour_q;
  logic              pix_blend_q, pix_last_q;

  assign left     = s1_xpos_q ? left_raw : '0;
  assign avg      = avg4(diag_q, left, above_q, s1_colour_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = s1_valid_q && out_free;
  assign s1_done  = emit && (s1_phase_q || !s1_blend_q);

  assign in_ready_o = !s1_valid_q || s1_done;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_phase_d  = s1_phase_q;
    diag_d      = diag_q;
    above_d     = above_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      s1_phase_d  = !s1_done;
    end
    if (s1_done) begin
      s1_valid_d = 1'b0;
      diag_d     = left;
      above_d    = s1_colour_q;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      s1_phase_q  <= 1'b0;
      diag_q      <= '0;
      above_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_cnt_q   <= col_cnt_d;
      row_cnt_q   <= row_cnt_d;
      s1_valid_q  <= s1_valid_d;
      s1_phase_q  <= s1_phase_d;
      diag_q      <= diag_d;
      above_q     <= above_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_colour_q <= cur_colour;
      s1_col_q    <= col_sum[CoordW-1:0];
      s1_row_q    <= row_sum[CoordW-1:0];
      s1_xpos_q   <= (x_cur != '0);
      s1_blend_q  <= (x_cur != '0) && (y_cur != '0);
    end
    if (emit) begin
      if (s1_phase_q) begin
        pix_col_q    <= s1_col_q - CoordW'(1);
        pix_row_q    <= s1_row_q;
        pix_colour_q <= avg;
        pix_blend_q  <= 1'b1;
        pix_last_q   <= 1'b1;
      end else begin
        pix_col_q    <= s1_col_q;
        pix_row_q    <= s1_row_q;
        pix_colour_q <= s1_colour_q;
        pix_blend_q  <= 1'b0;
        pix_last_q   <= !s1_blend_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_column_o = pix_col_q;
  assign pixel_row_o    = pix_row_q;
  assign pixel_colour_o = pix_colour_q;
  assign is_blended_o   = pix_blend_q;
  assign last_of_run_o  = pix_last_q;

endmodule
